[src/dual_down_counter_timer_macros.svh]
// Assertion helpers for the dual down-counter timer.
`ifndef DUAL_DOWN_COUNTER_TIMER_MACROS_SVH
`define DUAL_DOWN_COUNTER_TIMER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define DDCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define DDCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DDCT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DDCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/ddct_pkg.sv]
`default_nettype none

package ddct_pkg;

    localparam int TIMER_COUNT = 2;
    localparam int IRQ_W       = 2;

    // control register bit positions
    localparam int CTL_ENABLE   = 7;
    localparam int CTL_PERIODIC = 6;
    localparam int CTL_IE       = 5;
    localparam int CTL_DIV256   = 3;
    localparam int CTL_DIV16    = 2;
    localparam int CTL_WIDE     = 1;
    localparam int CTL_ONESHOT  = 0;

    localparam logic [7:0]  CTL_WRITE_MASK = 8'hEF;  // bit 4 reserved
    localparam logic [7:0]  CTL_RESET      = 8'h20;
    localparam logic [31:0] MASK_16        = 32'h0000_FFFF;
    localparam logic [7:0]  PRE_LAST_16    = 8'd15;
    localparam logic [7:0]  PRE_LAST_256   = 8'd255;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_LOAD    = 2'd0,
        REG_VALUE   = 2'd1,
        REG_CONTROL = 2'd2,
        REG_INTCLR  = 2'd3
    } t_reg_sel;

    typedef struct packed {
        t_opcode     opcode;
        logic        timer_select;
        t_reg_sel    register_select;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [31:0]      read_data;
        logic [IRQ_W-1:0] irq_lines;
    } t_rsp;

    typedef struct packed {
        logic [31:0] rd_data;
        logic        irq;
    } t_tmr_status;

endpackage

`default_nettype wire

[src/dual_down_counter_timer.sv]
// Dual down-counting timer with bus-style register access.
// Input channel: i_valid / o_stall carry one request (i_req) per cycle:
// a clock tick to all timers, a register write or a register read.
// Output channel: o_valid / i_stall carry one response (o_rsp) per request:
// read data (zero unless a read) and the per-timer interrupt lines as they
// stand after the request has taken effect.
// Pipeline: input register, then response register. Throughput is one
// request per clock while the receiver does not stall, set by the timer
// update that sits between the input register and the response register.
// Timer state advances only when a request moves into the response
// register, so ticks are counted exactly once whatever the stall pattern.
// When the receiver stalls, the held response stays put; the pending
// request waits in the input register and o_stall rises until the
// response is taken.
// Reset (synchronous, active low): both pipeline stages empty, each timer
// has load 0, value all ones, control 0x20 (interrupt enabled, stopped),
// prescaler 0 and no pending interrupt.

`default_nettype none

`include "dual_down_counter_timer_macros.svh"

module dual_down_counter_timer (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  ddct_pkg::t_req i_req,
    output logic           o_valid,
    input  wire            i_stall,
    output ddct_pkg::t_rsp o_rsp
);

    // input register
    logic           r_in_valid;
    ddct_pkg::t_req r_in;

    // response register
    logic           r_out_valid, n_out_valid;
    ddct_pkg::t_rsp r_out, n_out;

    logic advance;  // request in stage one commits this cycle

    ddct_pkg::t_tmr_status status [ddct_pkg::TIMER_COUNT];

    assign advance = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    for (genvar t = 0; t < ddct_pkg::TIMER_COUNT; t++) begin : g_tmr
        ddct_timer u_timer (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_commit (advance),
            .i_hit    (int'(r_in.timer_select) == t),
            .i_req    (r_in),
            .o_status (status[t])
        );
    end

    // merge timer outputs; only the selected timer drives read data
    always_comb begin
        n_out.read_data = '0;
        n_out.irq_lines = '0;
        for (int t = 0; t < ddct_pkg::TIMER_COUNT; t++) begin
            n_out.read_data = n_out.read_data | status[t].rd_data;
            if (t < ddct_pkg::IRQ_W) begin
                n_out.irq_lines[t] = status[t].irq;
            end
        end
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_req;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // non-read requests return zero data
    `DDCT_ASSERT_NEXT(a_rd_zero, i_clk, i_rst_n, advance && r_in.opcode != ddct_pkg::OP_READ, o_rsp.read_data == '0)

    // an interrupt clear on timer zero drops its line in the same response
    `DDCT_ASSERT_NEXT(a_intclr0, i_clk, i_rst_n, advance && r_in.opcode == ddct_pkg::OP_WRITE && r_in.timer_select == 1'b0 && r_in.register_select == ddct_pkg::REG_INTCLR, !o_rsp.irq_lines[0])

    // a full stage one with a blocked response must hold off the sender
    `DDCT_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, r_in_valid && !advance, o_stall)

endmodule

`default_nettype wire

[src/ddct_timer.sv]
`default_nettype none

`include "dual_down_counter_timer_macros.svh"

module ddct_timer (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_commit,
    input  wire                   i_hit,
    input  ddct_pkg::t_req        i_req,
    output ddct_pkg::t_tmr_status o_status
);

    logic [31:0] r_load,  n_load;
    logic [31:0] r_count, n_count;
    logic [7:0]  r_ctl,   n_ctl;
    logic [7:0]  r_pre,   n_pre;
    logic        r_raw,   n_raw;

    logic [31:0] mask;
    logic [31:0] cur;
    logic [31:0] dec;
    logic        pre_done;

    always_comb begin
        mask = r_ctl[ddct_pkg::CTL_WIDE] ? '1 : ddct_pkg::MASK_16;
        cur  = r_count & mask;
        dec  = cur - 32'd1;
        if (r_ctl[ddct_pkg::CTL_DIV256]) begin
            pre_done = (r_pre == ddct_pkg::PRE_LAST_256);
        end else if (r_ctl[ddct_pkg::CTL_DIV16]) begin
            pre_done = (r_pre >= ddct_pkg::PRE_LAST_16);
        end else begin
            pre_done = 1'b1;
        end
    end

    always_comb begin
        n_load  = r_load;
        n_count = r_count;
        n_ctl   = r_ctl;
        n_pre   = r_pre;
        n_raw   = r_raw;
        unique case (i_req.opcode)
            ddct_pkg::OP_TICK: begin
                if (r_ctl[ddct_pkg::CTL_ENABLE]) begin
                    if (pre_done) begin
                        n_pre = '0;
                        if (cur == '0) begin
                            if (r_ctl[ddct_pkg::CTL_ONESHOT]) begin
                                n_count = '0;
                            end else if (r_ctl[ddct_pkg::CTL_PERIODIC]) begin
                                n_count = r_load & mask;
                            end else begin
                                n_count = mask;
                            end
                        end else begin
                            n_count = dec;
                            if (dec == '0) begin
                                n_raw = 1'b1;
                            end
                        end
                    end else begin
                        n_pre = r_pre + 8'd1;
                    end
                end
            end
            ddct_pkg::OP_WRITE: begin
                if (i_hit) begin
                    unique case (i_req.register_select)
                        ddct_pkg::REG_LOAD: begin
                            n_load  = i_req.write_data;
                            n_count = i_req.write_data & mask;
                            n_pre   = '0;
                        end
                        ddct_pkg::REG_CONTROL: begin
                            n_ctl = i_req.write_data[7:0] & ddct_pkg::CTL_WRITE_MASK;
                            n_pre = '0;
                        end
                        ddct_pkg::REG_INTCLR: begin
                            n_raw = 1'b0;
                        end
                        ddct_pkg::REG_VALUE: begin
                            // read-only
                        end
                    endcase
                end
            end
            ddct_pkg::OP_READ, ddct_pkg::OP_NOP: begin
            end
        endcase
    end

    // read data from pre-step state; irq from post-step state
    always_comb begin
        o_status.rd_data = '0;
        if (i_hit && i_req.opcode == ddct_pkg::OP_READ) begin
            unique case (i_req.register_select)
                ddct_pkg::REG_LOAD:    o_status.rd_data = r_load;
                ddct_pkg::REG_VALUE:   o_status.rd_data = r_count;
                ddct_pkg::REG_CONTROL: o_status.rd_data = {24'd0, r_ctl};
                ddct_pkg::REG_INTCLR:  o_status.rd_data = '0;
            endcase
        end
        o_status.irq = n_raw & n_ctl[ddct_pkg::CTL_IE];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= '0;
            r_count <= '1;
            r_ctl   <= ddct_pkg::CTL_RESET;
            r_pre   <= '0;
            r_raw   <= 1'b0;
        end else if (i_commit) begin
            r_load  <= n_load;
            r_count <= n_count;
            r_ctl   <= n_ctl;
            r_pre   <= n_pre;
            r_raw   <= n_raw;
        end
    end

    // state only moves when a request is committed
    `DDCT_ASSERT_NEXT(a_hold_count, i_clk, i_rst_n, !i_commit, $stable(r_count) && $stable(r_raw))

    // reserved control bit never sets
    `DDCT_ASSERT_NOW(a_ctl_reserved, i_clk, i_rst_n, 1'b1, (r_ctl & ~ddct_pkg::CTL_WRITE_MASK) == '0)

    // divide by one keeps the prescaler at zero
    `DDCT_ASSERT_NOW(a_pre_div1, i_clk, i_rst_n, !r_ctl[ddct_pkg::CTL_DIV256] && !r_ctl[ddct_pkg::CTL_DIV16], r_pre == '0)

endmodule

`default_nettype wire

[test/dual_down_counter_timer_tb.sv]
`timescale 1ns / 100ps

module dual_down_counter_timer_tb;

    // Requests (ticks, register writes, register reads, no-ops) go in over the
    // valid/stall input channel. Each accepted request is run through a local
    // timer model right away, and its expected response is queued. A monitor
    // compares every accepted response, field by field, with the oldest queued
    // one. Both sides insert random gaps. One test holds the response side off
    // long enough to back the block up. Another pauses until nothing is pending.

    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned HOLD_CYCLES = 80;

    // inputs start known; after that they are driven only at the rising edge
    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           i_stall = 1'b0;
    ddct_pkg::t_req i_req   = '0;
    logic           o_stall;
    logic           o_valid;
    ddct_pkg::t_rsp o_rsp;

    // timer state as seen by the model
    logic [31:0] load_reg [ddct_pkg::TIMER_COUNT];
    logic [31:0] count_reg [ddct_pkg::TIMER_COUNT];
    logic [7:0]  ctl_reg [ddct_pkg::TIMER_COUNT];
    int unsigned prescale [ddct_pkg::TIMER_COUNT];
    bit          raw_irq [ddct_pkg::TIMER_COUNT];

    ddct_pkg::t_rsp expected_rsp_q [$];
    int unsigned error_count = 0;
    int unsigned requests_sent = 0;
    int unsigned responses_seen = 0;
    int unsigned irq_responses = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_cycles = 0;  // one-shot long hold for the response side
    bit          gapless = 1'b0;   // both sides run without idle cycles

    dual_down_counter_timer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Timer model
    // ---------------------------------------------------------------
    function automatic void clear_timers();
        for (int t = 0; t < ddct_pkg::TIMER_COUNT; t++) begin
            load_reg[t]  = '0;
            count_reg[t] = '1;
            ctl_reg[t]   = ddct_pkg::CTL_RESET;
            prescale[t]  = 0;
            raw_irq[t]   = 1'b0;
        end
    endfunction

    function automatic logic [31:0] width_mask(int t);
        return ctl_reg[t][ddct_pkg::CTL_WIDE] ? 32'hFFFF_FFFF : ddct_pkg::MASK_16;
    endfunction

    // One count step. The interrupt fires on the step into zero only, so a
    // counter sitting at zero stays, reloads or wraps silently.
    function automatic void count_down(int t);
        logic [31:0] m;
        logic [31:0] c;
        m = width_mask(t);
        c = count_reg[t] & m;
        if (c == 0) begin
            if (ctl_reg[t][ddct_pkg::CTL_ONESHOT])
                c = '0;
            else if (ctl_reg[t][ddct_pkg::CTL_PERIODIC])
                c = load_reg[t] & m;
            else
                c = m;
        end else begin
            c = c - 32'd1;
            if (c == 0)
                raw_irq[t] = 1'b1;
        end
        count_reg[t] = c;
    endfunction

    // Prescale code 11 divides by 256, same as 10.
    function automatic void tick_timer(int t);
        int unsigned div;
        if (!ctl_reg[t][ddct_pkg::CTL_ENABLE])
            return;
        div = ctl_reg[t][ddct_pkg::CTL_DIV256] ? 256 :
              (ctl_reg[t][ddct_pkg::CTL_DIV16] ? 16 : 1);
        if (prescale[t] + 1 >= div) begin
            prescale[t] = 0;
            count_down(t);
        end else begin
            prescale[t]++;
        end
    endfunction

    function automatic ddct_pkg::t_rsp apply_request(ddct_pkg::t_req r);
        ddct_pkg::t_rsp rsp;
        int             sel;
        rsp = '0;
        sel = int'(r.timer_select);
        case (r.opcode)
            ddct_pkg::OP_TICK: begin
                for (int t = 0; t < ddct_pkg::TIMER_COUNT; t++)
                    tick_timer(t);
            end
            ddct_pkg::OP_WRITE: begin
                if (sel < ddct_pkg::TIMER_COUNT) begin
                    case (r.register_select)
                        ddct_pkg::REG_LOAD: begin
                            load_reg[sel]  = r.write_data;
                            count_reg[sel] = r.write_data & width_mask(sel);
                            prescale[sel]  = 0;
                        end
                        ddct_pkg::REG_CONTROL: begin
                            ctl_reg[sel]  = r.write_data[7:0] & ddct_pkg::CTL_WRITE_MASK;
                            prescale[sel] = 0;
                        end
                        ddct_pkg::REG_INTCLR: raw_irq[sel] = 1'b0;
                        default: ;  // current value is read-only
                    endcase
                end
            end
            ddct_pkg::OP_READ: begin
                if (sel < ddct_pkg::TIMER_COUNT) begin
                    case (r.register_select)
                        ddct_pkg::REG_LOAD:    rsp.read_data = load_reg[sel];
                        ddct_pkg::REG_VALUE:   rsp.read_data = count_reg[sel];
                        ddct_pkg::REG_CONTROL: rsp.read_data = {24'd0, ctl_reg[sel]};
                        default:               rsp.read_data = '0;
                    endcase
                end
            end
            default: ;  // no-op
        endcase
        for (int t = 0; t < ddct_pkg::TIMER_COUNT && t < ddct_pkg::IRQ_W; t++)
            rsp.irq_lines[t] = raw_irq[t] & ctl_reg[t][ddct_pkg::CTL_IE];
        return rsp;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    function automatic int unsigned pick_wait();
        if (gapless)
            return 0;
        // about two fifths of the draws are zero so bursts still happen
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic ddct_pkg::t_req make_req(ddct_pkg::t_opcode op, bit sel,
                                                ddct_pkg::t_reg_sel rs,
                                                logic [31:0] d);
        ddct_pkg::t_req r;
        r.opcode          = op;
        r.timer_select    = sel;
        r.register_select = rs;
        r.write_data      = d;
        return r;
    endfunction

    // Offers one request and blocks until it is taken. Valid stays high
    // into the next call when that call draws no gap.
    task automatic send_req(ddct_pkg::t_req r);
        int unsigned gap;
        gap = pick_wait();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req   <= r;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        expected_rsp_q.push_back(apply_request(r));
        requests_sent++;
    endtask

    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Tick-heavy mix of everything the bus can do.
    function automatic ddct_pkg::t_req random_request();
        int unsigned pick;
        bit          sel;
        logic [31:0] d;
        pick = $urandom_range(0, 99);
        sel  = 1'($urandom_range(0, 1));
        d    = $urandom();
        if (pick < 55)
            return make_req(ddct_pkg::OP_TICK, sel,
                            ddct_pkg::t_reg_sel'($urandom_range(0, 3)), d);
        if (pick < 70)
            return make_req(ddct_pkg::OP_READ, sel,
                            ddct_pkg::t_reg_sel'($urandom_range(0, 3)), d);
        if (pick < 80) begin
            if ($urandom_range(0, 3) != 0)
                d[15:0] = 16'($urandom_range(0, 40));
            return make_req(ddct_pkg::OP_WRITE, sel, ddct_pkg::REG_LOAD, d);
        end
        if (pick < 86)
            return make_req(ddct_pkg::OP_WRITE, sel, ddct_pkg::REG_CONTROL, d);
        if (pick < 93)
            return make_req(ddct_pkg::OP_WRITE, sel, ddct_pkg::REG_INTCLR, d);
        if (pick < 96)
            return make_req(ddct_pkg::OP_WRITE, sel, ddct_pkg::REG_VALUE, d);
        return make_req(ddct_pkg::OP_NOP, sel,
                        ddct_pkg::t_reg_sel'($urandom_range(0, 3)), d);
    endfunction

    // ---------------------------------------------------------------
    // Response side: random stall per response, plus a long hold on demand
    // ---------------------------------------------------------------
    initial begin
        int unsigned n;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_cycles != 0) begin
                n = hold_cycles;
                hold_cycles = 0;
            end else begin
                n = pick_wait();
            end
            if (n != 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_stall === 1'b0));
        end
    end

    // Response checker
    always @(posedge i_clk) begin
        ddct_pkg::t_rsp exp_rsp;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            responses_seen++;
            if (o_rsp.irq_lines != 0)
                irq_responses++;
            if (expected_rsp_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected response read_data=%h irq_lines=%b",
                         $time, o_rsp.read_data, o_rsp.irq_lines);
            end else begin
                exp_rsp = expected_rsp_q.pop_front();
                if (o_rsp.read_data !== exp_rsp.read_data) begin
                    error_count++;
                    $display("%0t: read_data expected %h actual %h",
                             $time, exp_rsp.read_data, o_rsp.read_data);
                end
                if (o_rsp.irq_lines !== exp_rsp.irq_lines) begin
                    error_count++;
                    $display("%0t: irq_lines expected %b actual %b",
                             $time, exp_rsp.irq_lines, o_rsp.irq_lines);
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d responses pending",
                 $time, expected_rsp_q.size());
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Every register of both timers straight out of reset; the interrupt
    // clear register reads as zero.
    task automatic test_reset_values();
        for (int t = 0; t < 2; t++)
            for (int rs = 0; rs < 4; rs++)
                send_req(make_req(ddct_pkg::OP_READ, 1'(t), ddct_pkg::t_reg_sel'(rs), '0));
    endtask

    task automatic test_register_writes();
        // current value is read-only
        send_req(make_req(ddct_pkg::OP_WRITE, 1'b0, ddct_pkg::REG_VALUE, 32'h1234_5678));
        // reserved bit 4 drops out; prescale code 11 reads back as written
        send_req(make_req(ddct_pkg::OP_WRITE, 1'b0, ddct_pkg::REG_CONTROL, 32'hFFFF_FFFF));
        send_req(make_req(ddct_pkg::OP_READ, 1'b0, ddct_pkg::REG_CONTROL, '0));
        send_req(make_req(ddct_pkg::OP_WRITE, 1'b0, ddct_pkg::REG_LOAD, 32'hFFFF_FFFF));
        send_req(make_req(ddct_pkg::OP_NOP, 1'b1, ddct_pkg::REG_INTCLR, 32'hFFFF_FFFF));
    endtask

    task automatic test_count_modes();
        // 16-bit one-shot: upper load bits masked off the count, interrupt
        // on reaching zero, then it sits at zero
        send_req(make_req(ddct_pkg::OP_WRITE, 1'b1, ddct_pkg::REG_LOAD, 32'hABCD_0002));
        send_req(make_req(ddct_pkg::OP_WRITE, 1'b1, ddct_pkg::REG_CONTROL, 32'h0000_00A1));
        repeat (3) send_req(make_req(ddct_pkg::OP_TICK, 1'b0, ddct_pkg::REG_LOAD, '0));
        send_req(make_req(ddct_pkg::OP_READ, 1'b1, ddct_pkg::REG_VALUE, '0));
        send_req(make_req(ddct_pkg::OP_WRITE, 1'b1, ddct_pkg::REG_INTCLR, 32'hFFFF_FFFF));
        // periodic with zero load: reloads zero, no interrupt
        send_req(make_req(ddct_pkg::OP_WRITE, 1'b1, ddct_pkg::REG_LOAD, '0));
        send_req(make_req(ddct_pkg::OP_WRITE, 1'b1, ddct_pkg::REG_CONTROL, 32'h0000_00E2));
        send_req(make_req(ddct_pkg::OP_TICK, 1'b1, ddct_pkg::REG_VALUE, '0));
        // free-running 16-bit from zero wraps to 0xFFFF, interrupt masked
        send_req(make_req(ddct_pkg::OP_WRITE, 1'b1, ddct_pkg::REG_CONTROL, 32'h0000_0080));
        send_req(make_req(ddct_pkg::OP_TICK, 1'b1, ddct_pkg::REG_CONTROL, '0));
        send_req(make_req(ddct_pkg::OP_READ, 1'b1, ddct_pkg::REG_VALUE, '0));
    endtask

    // Per round: set up one timer with a short count, then let mixed
    // traffic run over it.
    task automatic test_random_sequences(int unsigned rounds, int unsigned per_round);
        bit          sel;
        logic [31:0] ctl;
        logic [31:0] d;
        for (int unsigned k = 0; k < rounds; k++) begin
            sel = 1'($urandom_range(0, 1));
            ctl = $urandom();
            ctl[ddct_pkg::CTL_ENABLE] = ($urandom_range(0, 5) != 0);
            if ($urandom_range(0, 3) != 0)
                ctl[ddct_pkg::CTL_DIV256:ddct_pkg::CTL_DIV16] = 2'b00;
            d = $urandom();
            if ($urandom_range(0, 4) != 0) begin
                d[15:0] = 16'($urandom_range(0, 40));
                if (ctl[ddct_pkg::CTL_WIDE])
                    d[31:16] = '0;
            end
            send_req(make_req(ddct_pkg::OP_WRITE, sel, ddct_pkg::REG_CONTROL, ctl));
            send_req(make_req(ddct_pkg::OP_WRITE, sel, ddct_pkg::REG_LOAD, d));
            repeat (per_round) send_req(random_request());
        end
    endtask

    task automatic test_back_to_back(int unsigned count);
        gapless = 1'b1;
        repeat (count) send_req(random_request());
        gapless = 1'b0;
    endtask

    // Response side holds off while requests keep coming, so both pipeline
    // stages fill and o_stall has to rise.
    task automatic test_receiver_hold(int unsigned count);
        hold_cycles = HOLD_CYCLES;
        gapless     = 1'b1;
        repeat (count) send_req(random_request());
        gapless     = 1'b0;
    endtask

    task automatic test_pause_until_empty(int unsigned count);
        repeat (count) send_req(random_request());
        wait_until_drained();
        repeat (count) send_req(random_request());
    endtask

    initial begin
        clear_timers();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_register_writes();
        test_count_modes();
        test_random_sequences(17, 40);
        test_back_to_back(60);
        test_receiver_hold(30);
        test_pause_until_empty(12);

        wait_until_drained();
        repeat (4) @(posedge i_clk);

        $display("Ran %0d requests (ticks, register access, no-ops) with random gaps,",
                 requests_sent);
        $display("a long response hold and a full drain; %0d responses, %0d with an irq.",
                 responses_seen, irq_responses);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
